>>> hdl/mtr_pkg.sv
// Shared package for the Morton position-to-rank lookup.
// Holds field widths, status and mode codes, register indexes and the token flag type.
// No dependencies.
`default_nettype none

package mtr_pkg;

  localparam int MTR_MAX_RANKS_DEF  = 64;
  localparam int MTR_COORD_BITS_DEF = 10;

  localparam int VAL_W    = 30;
  localparam int POS_W    = 32;
  localparam int SLOT_W   = 7;
  localparam int OWNER_W  = 6;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;
  localparam int NR_W     = 7;

  localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BELOW  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BEYOND = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_UNUSED = 2'd3;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_INV_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_Z     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_RANKS = 3'd3;

  localparam logic [POS_W-1:0] INV_CELL_RESET  = 32'd65536;
  localparam logic [NR_W-1:0]  NUM_RANKS_RESET = 7'd1;

  // Control bits of a query word as it walks along the cell row.
  typedef struct packed {
    logic valid;
    logic found;
    logic beyond;
  } mtr_flags_t;

endpackage : mtr_pkg

`default_nettype wire

>>> hdl/mtr_scale.sv
// Coordinate scaling front end: one shared 32x32 multiplier, saturation and bit interleave.
// Depends on mtr_pkg.
`default_nettype none

module mtr_scale #(
  parameter int COORD_BITS = 10
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [mtr_pkg::POS_W-1:0]       pos_x_i,
  input  logic [mtr_pkg::POS_W-1:0]       pos_y_i,
  input  logic [mtr_pkg::POS_W-1:0]       pos_z_i,
  input  logic [mtr_pkg::POS_W-1:0]       inv_x_i,
  input  logic [mtr_pkg::POS_W-1:0]       inv_y_i,
  input  logic [mtr_pkg::POS_W-1:0]       inv_z_i,
  output logic                            busy_o,
  output logic                            launch_o,
  output logic [3*COORD_BITS-1:0]         morton_o
);
  import mtr_pkg::*;

  localparam logic [POS_W-1:0] CMAX = POS_W'((64'd1 << COORD_BITS) - 64'd1);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_RUN    = 3'b010,
    ST_LAUNCH = 3'b100
  } scale_state_e;

  scale_state_e            state_q, state_d;
  logic [2:0]              step_q, step_d;
  logic [POS_W-1:0]        pos_q [3];
  logic [2*POS_W-1:0]      prod_q;
  logic [COORD_BITS-1:0]   coord_q [3];
  logic [1:0]              axis;
  logic [POS_W-1:0]        mul_a, mul_b, cell_int;
  logic [COORD_BITS-1:0]   cell_sat;

  assign axis = step_q[2:1];

  always_comb begin
    case (axis)
      2'd0: begin
        mul_a = pos_q[0];
        mul_b = inv_x_i;
      end
      2'd1: begin
        mul_a = pos_q[1];
        mul_b = inv_y_i;
      end
      2'd2: begin
        mul_a = pos_q[2];
        mul_b = inv_z_i;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign cell_int = prod_q[2*POS_W-1:POS_W];
  assign cell_sat = (cell_int > CMAX) ? CMAX[COORD_BITS-1:0] : cell_int[COORD_BITS-1:0];

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_RUN;
          step_d  = 3'd0;
        end
      end
      ST_RUN: begin
        if (step_q == 3'd5) begin
          state_d = ST_LAUNCH;
        end else begin
          step_d = step_q + 3'd1;
        end
      end
      ST_LAUNCH: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= 3'd0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // Even steps multiply one axis, odd steps saturate that product.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start_i) begin
      pos_q[0] <= pos_x_i;
      pos_q[1] <= pos_y_i;
      pos_q[2] <= pos_z_i;
    end
    if (state_q == ST_RUN) begin
      if (!step_q[0]) begin
        prod_q <= mul_a * mul_b;
      end else if (axis != 2'd3) begin
        coord_q[axis] <= cell_sat;
      end
    end
  end

  always_comb begin
    morton_o = '0;
    for (int b = 0; b < COORD_BITS; b++) begin
      morton_o[3*b]   = coord_q[0][b];
      morton_o[3*b+1] = coord_q[1][b];
      morton_o[3*b+2] = coord_q[2][b];
    end
  end

  assign busy_o   = (state_q != ST_IDLE);
  assign launch_o = (state_q == ST_LAUNCH);

endmodule : mtr_scale

`default_nettype wire

>>> hdl/mtr_cell.sv
// One cell of the lookup row: holds one table entry and updates the passing query word.
// Depends on mtr_pkg.
`default_nettype none

module mtr_cell #(
  parameter int IDX = 0,
  parameter int MW  = 30,
  parameter int OW  = 6,
  parameter int NW  = 7
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         wr_en_i,
  input  logic [mtr_pkg::SLOT_W-1:0]   wr_slot_i,
  input  logic [mtr_pkg::VAL_W-1:0]    wr_value_i,
  input  mtr_pkg::mtr_flags_t          flags_i,
  input  logic [MW-1:0]                m_i,
  input  logic [NW-1:0]                n_i,
  input  logic [OW-1:0]                owner_i,
  output mtr_pkg::mtr_flags_t          flags_o,
  output logic [MW-1:0]                m_o,
  output logic [NW-1:0]                n_o,
  output logic [OW-1:0]                owner_o
);
  import mtr_pkg::*;

  localparam int CW = (MW > VAL_W) ? MW : VAL_W;

  logic [VAL_W-1:0] entry_q;
  mtr_flags_t       flags_q, flags_d;
  logic [MW-1:0]    m_q;
  logic [NW-1:0]    n_q;
  logic [OW-1:0]    owner_q, owner_d;
  logic             not_above;

  assign not_above = CW'(entry_q) <= CW'(m_i);

  always_comb begin
    flags_d = flags_i;
    owner_d = owner_i;
    if (n_i > NW'(IDX) && not_above) begin
      flags_d.found = 1'b1;
      owner_d       = OW'(IDX);
    end
    if (n_i == NW'(IDX)) begin
      flags_d.beyond = not_above;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i && (32'(wr_slot_i) == IDX)) begin
      entry_q <= wr_value_i;
    end
    if (en_i) begin
      m_q     <= m_i;
      n_q     <= n_i;
      owner_q <= owner_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (en_i) begin
      flags_q <= flags_d;
    end
  end

  assign flags_o = flags_q;
  assign m_o     = m_q;
  assign n_o     = n_q;
  assign owner_o = owner_q;

endmodule : mtr_cell

`default_nettype wire

>>> hdl/morton_position_to_rank_top.sv
// Top level of the Morton position-to-rank lookup: configuration, scaling front end,
// the row of table cells and the result register. Depends on mtr_pkg, mtr_scale, mtr_cell.
//
//   Channel  | Handshake                | Word
//   ---------+--------------------------+---------------------------------------------
//   in       | in_valid_i / in_stall_o  | mode, pos_x/y/z, entry_slot, entry_value
//   out      | out_valid_o / out_stall_i| proc_owner, status, morton_index
//   cfg      | cfg_valid_i / cfg_ready_o| cfg_index, cfg_data
//
// A load word is written straight into its table slot. A query word passes through the single
// shared multiplier (multiply, then saturate, for each axis), a launch step, each cell of
// the MAX_RANKS + 1 cell row and the result register; no new word is accepted until it has
// left the row. Reset clears control state only; table entries are undefined until loaded,
// so there is no clearing pass. A stalled result holds the row only when a finished query
// reaches its end, and no new word is taken meanwhile.
`default_nettype none

module morton_position_to_rank_top #(
  parameter int MAX_RANKS  = mtr_pkg::MTR_MAX_RANKS_DEF,
  parameter int COORD_BITS = mtr_pkg::MTR_COORD_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             mode_i,
  input  logic [mtr_pkg::POS_W-1:0]        pos_x_i,
  input  logic [mtr_pkg::POS_W-1:0]        pos_y_i,
  input  logic [mtr_pkg::POS_W-1:0]        pos_z_i,
  input  logic [mtr_pkg::SLOT_W-1:0]       entry_slot_i,
  input  logic [mtr_pkg::VAL_W-1:0]        entry_value_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [mtr_pkg::OWNER_W-1:0]      proc_owner_o,
  output logic [mtr_pkg::STATUS_W-1:0]     status_o,
  output logic [mtr_pkg::VAL_W-1:0]        morton_index_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [mtr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [mtr_pkg::CFG_DAT_W-1:0]    cfg_data_i
);
  import mtr_pkg::*;

  // Depth of the row: entries 0 to MAX_RANKS, the last one being the grid end.
  localparam int D   = MAX_RANKS + 1;
  localparam int MW  = 3 * COORD_BITS;
  localparam int OW  = (MAX_RANKS > 1) ? $clog2(MAX_RANKS) : 1;
  localparam int NW  = $clog2(MAX_RANKS + 1);
  localparam int NRW = (NW > NR_W) ? NW : NR_W;

  // Configuration registers. The port is always ready; writes happen while idle only if the user ensures it.
  logic [POS_W-1:0] inv_x_q, inv_y_q, inv_z_q;
  logic [NR_W-1:0]  num_ranks_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_x_q     <= INV_CELL_RESET;
      inv_y_q     <= INV_CELL_RESET;
      inv_z_q     <= INV_CELL_RESET;
      num_ranks_q <= NUM_RANKS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_INV_X:     inv_x_q     <= cfg_data_i;
        CFG_INV_Y:     inv_y_q     <= cfg_data_i;
        CFG_INV_Z:     inv_z_q     <= cfg_data_i;
        CFG_NUM_RANKS: num_ranks_q <= cfg_data_i[NR_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective rank count, clamped to one to MAX_RANKS.
  logic [NRW-1:0] nr_ext;
  logic [NW-1:0]  n_eff;

  assign nr_ext = NRW'(num_ranks_q);

  always_comb begin
    if (nr_ext == '0) begin
      n_eff = NW'(1);
    end else if (nr_ext > NRW'(MAX_RANKS)) begin
      n_eff = NW'(MAX_RANKS);
    end else begin
      n_eff = nr_ext[NW-1:0];
    end
  end

  // Input acceptance. Only one query is ever in flight, and a load waits until the row is
  // empty so that it cannot overtake a query still on its way down the row.
  logic       in_fire, query_go, load_go;
  logic       scale_busy, scale_launch;
  logic [MW-1:0] scale_m;
  logic [D:0] tok_vld;

  assign in_stall_o = scale_busy | (|tok_vld);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign query_go   = in_fire && (mode_i == MODE_QUERY);
  assign load_go    = in_fire && (mode_i == MODE_LOAD);

  mtr_scale #(
    .COORD_BITS (COORD_BITS)
  ) u_scale (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (query_go),
    .pos_x_i  (pos_x_i),
    .pos_y_i  (pos_y_i),
    .pos_z_i  (pos_z_i),
    .inv_x_i  (inv_x_q),
    .inv_y_i  (inv_y_q),
    .inv_z_i  (inv_z_q),
    .busy_o   (scale_busy),
    .launch_o (scale_launch),
    .morton_o (scale_m)
  );

  // The cell row. Stage 0 is the word coming out of the scaler; stage k+1 is cell k.
  mtr_flags_t     flags [D+1];
  logic [MW-1:0]  m_s   [D+1];
  logic [NW-1:0]  n_s   [D+1];
  logic [OW-1:0]  own_s [D+1];
  logic           row_en;
  logic           out_load;

  assign flags[0].valid  = scale_launch;
  assign flags[0].found  = 1'b0;
  assign flags[0].beyond = 1'b0;
  assign m_s[0]          = scale_m;
  assign n_s[0]          = n_eff;
  assign own_s[0]        = '0;

  // The row only freezes when a finished query meets a result that is still stalled.
  assign row_en   = !(flags[D].valid && out_valid_o && out_stall_i);
  assign out_load = flags[D].valid && row_en;

  for (genvar k = 0; k <= D; k++) begin : g_vld
    assign tok_vld[k] = flags[k].valid;
  end

  for (genvar k = 0; k < D; k++) begin : g_cell
    mtr_cell #(
      .IDX (k),
      .MW  (MW),
      .OW  (OW),
      .NW  (NW)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (row_en),
      .wr_en_i    (load_go),
      .wr_slot_i  (entry_slot_i),
      .wr_value_i (entry_value_i),
      .flags_i    (flags[k]),
      .m_i        (m_s[k]),
      .n_i        (n_s[k]),
      .owner_i    (own_s[k]),
      .flags_o    (flags[k+1]),
      .m_o        (m_s[k+1]),
      .n_o        (n_s[k+1]),
      .owner_o    (own_s[k+1])
    );
  end

  // Result register. The grid-end check wins over the below-first-entry case, and the
  // owner reads as zero whenever the status is not ok.
  logic                 out_valid_q;
  logic [OWNER_W-1:0]   owner_q;
  logic [STATUS_W-1:0]  status_q;
  logic [VAL_W-1:0]     morton_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      morton_q <= VAL_W'(m_s[D]);
      if (flags[D].beyond) begin
        status_q <= STATUS_BEYOND;
        owner_q  <= '0;
      end else if (!flags[D].found) begin
        status_q <= STATUS_BELOW;
        owner_q  <= '0;
      end else begin
        status_q <= STATUS_OK;
        owner_q  <= OWNER_W'(own_s[D]);
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign proc_owner_o   = owner_q;
  assign status_o       = status_q;
  assign morton_index_o = morton_q;

`ifndef SYNTHESIS
  // Only one query word may be on its way down the row at any time.
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(tok_vld))
    else $error("more than one query word in the cell row");

  // While a query is in the row, no new word may be taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni) (|tok_vld) |-> in_stall_o)
    else $error("input accepted while a query is in flight");

  // A result never carries the unused status code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o != STATUS_UNUSED))
    else $error("result carries an unused status code");

  // A failed lookup reports owner zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != STATUS_OK)) |-> (proc_owner_o == '0))
    else $error("owner not cleared on a failed lookup");

  // A query accepted now reaches the first cell once the scaler has run its steps and reached its launch state.
  assert property (@(posedge clk_i) disable iff (!rst_ni) query_go |-> ##7 scale_launch)
    else $error("scaler launch out of step");
`endif

endmodule : morton_position_to_rank_top

`default_nettype wire
